### rtl/psqm_pkg.sv
// Package: shared constants, codes and control types of the process state queue manager.
`timescale 1ns / 1ps
`default_nettype none
package psqm_pkg;

  localparam int MAX_PROCS = 16;
  localparam int ID_BITS   = 16;
  localparam int PTR_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  localparam int NUM_Q       = 3;
  localparam int IDX_NEW     = 0;
  localparam int IDX_READY   = 1;
  localparam int IDX_BLOCKED = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 3'd0,
    CMD_DISPATCH = 3'd1,
    CMD_TIMEOUT  = 3'd2,
    CMD_WAIT     = 3'd3,
    CMD_EVENT    = 3'd4,
    CMD_ADMIT    = 3'd5,
    CMD_RELEASE  = 3'd6,
    CMD_INVALID  = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_NO_MOVE = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_INVALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    Q_NONE    = 2'd0,
    Q_NEW     = 2'd1,
    Q_READY   = 2'd2,
    Q_BLOCKED = 2'd3
  } queue_e;

  typedef enum logic [1:0] {
    SRC_PID = 2'd0,
    SRC_RUN = 2'd1,
    SRC_POP = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    RUN_KEEP  = 2'd0,
    RUN_SET   = 2'd1,
    RUN_CLEAR = 2'd2
  } run_op_e;

  typedef struct packed {
    status_e status;
    queue_e  pop_q;
    queue_e  push_q;
    src_e    push_src;
    run_op_e run_op;
    logic    rel;
  } plan_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    logic  commit;
    plan_t plan;
  } dp_ctrl_t;

  typedef struct packed {
    logic             run_valid;
    logic [NUM_Q-1:0] empty;
    logic [NUM_Q-1:0] full;
    logic             out_free;
  } dp_stat_t;

  function automatic logic [NUM_Q-1:0] q_mask(queue_e q);
    logic [NUM_Q-1:0] m;
    m = '0;
    case (q)
      Q_NEW:     m[IDX_NEW]     = 1'b1;
      Q_READY:   m[IDX_READY]   = 1'b1;
      Q_BLOCKED: m[IDX_BLOCKED] = 1'b1;
      default:   m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_PROCS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

### rtl/psqm_if.sv
// Interfaces: request and result channels of the process state queue manager.
`timescale 1ns / 1ps
`default_nettype none
interface psqm_req_if import psqm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_BITS-1:0] process_id;

  modport source (output valid, command, process_id, input ready);
  modport sink   (input valid, command, process_id, output ready);
endinterface

interface psqm_rsp_if import psqm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               running_valid;
  logic [ID_BITS-1:0] running_id;
  logic               released_valid;
  logic [ID_BITS-1:0] released_id;
  logic [CNT_W-1:0]   new_count;
  logic [CNT_W-1:0]   ready_count;
  logic [CNT_W-1:0]   blocked_count;

  modport source (output valid, status, running_valid, running_id, released_valid,
                  released_id, new_count, ready_count, blocked_count, input ready);
  modport sink   (input valid, status, running_valid, running_id, released_valid,
                  released_id, new_count, ready_count, blocked_count, output ready);
endinterface
`default_nettype wire

### rtl/psqm_ctrl.sv
// Controller: request sequencing and move planning for each command.
`timescale 1ns / 1ps
`default_nettype none
module psqm_ctrl import psqm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  psqm_req_if.sink      req_i,
  input  wire dp_stat_t stat_i,
  output dp_ctrl_t      ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  plan_t  plan_q, plan_d;
  logic   accept;
  logic   commit;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == S_WRITE) && stat_i.out_free;

  always_comb begin
    plan_d          = '0;
    plan_d.status   = STAT_DONE;
    plan_d.pop_q    = Q_NONE;
    plan_d.push_q   = Q_NONE;
    plan_d.push_src = SRC_PID;
    plan_d.run_op   = RUN_KEEP;
    plan_d.rel      = 1'b0;
    case (cmd_q)
      CMD_LOAD: begin
        if (stat_i.full[IDX_NEW]) begin
          plan_d.status = STAT_FULL;
        end else begin
          plan_d.push_q = Q_NEW;
        end
      end
      CMD_DISPATCH: begin
        plan_d.push_src = SRC_RUN;
        if (!stat_i.empty[IDX_READY]) begin
          if (stat_i.run_valid && stat_i.full[IDX_BLOCKED]) begin
            plan_d.status = STAT_NO_MOVE;
          end else begin
            plan_d.pop_q  = Q_READY;
            plan_d.push_q = stat_i.run_valid ? Q_BLOCKED : Q_NONE;
            plan_d.run_op = RUN_SET;
          end
        end else if (!stat_i.empty[IDX_BLOCKED]) begin
          plan_d.pop_q  = Q_BLOCKED;
          plan_d.push_q = stat_i.run_valid ? Q_BLOCKED : Q_NONE;
          plan_d.run_op = RUN_SET;
        end else begin
          plan_d.status = STAT_NO_MOVE;
        end
      end
      CMD_TIMEOUT: begin
        plan_d.push_src = SRC_RUN;
        if (!stat_i.run_valid || stat_i.empty[IDX_READY]) begin
          plan_d.status = STAT_NO_MOVE;
        end else begin
          plan_d.pop_q  = Q_READY;
          plan_d.push_q = Q_READY;
          plan_d.run_op = RUN_SET;
        end
      end
      CMD_WAIT: begin
        plan_d.push_src = SRC_RUN;
        if (!stat_i.run_valid) begin
          plan_d.status = STAT_NO_MOVE;
        end else if (!stat_i.empty[IDX_READY]) begin
          if (stat_i.full[IDX_BLOCKED]) begin
            plan_d.status = STAT_NO_MOVE;
          end else begin
            plan_d.pop_q  = Q_READY;
            plan_d.push_q = Q_BLOCKED;
            plan_d.run_op = RUN_SET;
          end
        end else if (!stat_i.empty[IDX_BLOCKED]) begin
          plan_d.pop_q  = Q_BLOCKED;
          plan_d.push_q = Q_BLOCKED;
          plan_d.run_op = RUN_SET;
        end
        // blocked empty: running ID would come straight back, nothing moves
      end
      CMD_EVENT: begin
        if (stat_i.empty[IDX_BLOCKED] || stat_i.full[IDX_READY]) begin
          plan_d.status = STAT_NO_MOVE;
        end else begin
          plan_d.pop_q    = Q_BLOCKED;
          plan_d.push_q   = Q_READY;
          plan_d.push_src = SRC_POP;
        end
      end
      CMD_ADMIT: begin
        if (stat_i.empty[IDX_NEW] || stat_i.full[IDX_READY]) begin
          plan_d.status = STAT_NO_MOVE;
        end else begin
          plan_d.pop_q    = Q_NEW;
          plan_d.push_q   = Q_READY;
          plan_d.push_src = SRC_POP;
        end
      end
      CMD_RELEASE: begin
        if (!stat_i.run_valid) begin
          plan_d.status = STAT_NO_MOVE;
        end else begin
          plan_d.rel = 1'b1;
          if (!stat_i.empty[IDX_READY]) begin
            plan_d.pop_q  = Q_READY;
            plan_d.run_op = RUN_SET;
          end else begin
            plan_d.run_op = RUN_CLEAR;
          end
        end
      end
      default: begin
        plan_d.status = STAT_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_INVALID;
      plan_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_e'(req_i.command);
            state_q <= S_READ;
          end
        end
        S_READ: begin
          plan_q  <= plan_d;
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign ctrl_o.load   = accept;
  assign ctrl_o.rd_en  = (state_q == S_READ);
  assign ctrl_o.commit = commit;
  assign ctrl_o.plan   = plan_q;

  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("accepted request did not start a head read");

endmodule
`default_nettype wire

### rtl/psqm_dp.sv
// Datapath: queue memories, pointers, counts, running slot and result register.
`timescale 1ns / 1ps
`default_nettype none
module psqm_dp import psqm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ID_BITS-1:0] pid_i,
  input  wire dp_ctrl_t           ctrl_i,
  output dp_stat_t                stat_o,
  psqm_rsp_if.source              rsp_o
);

  logic [ID_BITS-1:0] mem_q  [NUM_Q][MAX_PROCS];
  logic [ID_BITS-1:0] rd_q   [NUM_Q];
  logic [PTR_W-1:0]   head_q [NUM_Q];
  logic [PTR_W-1:0]   head_d [NUM_Q];
  logic [PTR_W-1:0]   tail_q [NUM_Q];
  logic [PTR_W-1:0]   tail_d [NUM_Q];
  logic [CNT_W-1:0]   cnt_q  [NUM_Q];
  logic [CNT_W-1:0]   cnt_d  [NUM_Q];

  logic [ID_BITS-1:0] pid_q;
  logic               run_valid_q, run_valid_d;
  logic [ID_BITS-1:0] run_id_q, run_id_d;

  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic               out_run_v_q;
  logic [ID_BITS-1:0] out_run_id_q;
  logic               out_rel_v_q;
  logic [ID_BITS-1:0] out_rel_id_q;
  logic [CNT_W-1:0]   out_cnt_q [NUM_Q];

  logic [NUM_Q-1:0]   pop_sel, pop_m, push_m, empty_v, full_v;
  logic [ID_BITS-1:0] popped, push_data;
  logic               out_free;
  plan_t              plan;

  assign plan     = ctrl_i.plan;
  assign pop_sel  = q_mask(plan.pop_q);
  assign pop_m    = pop_sel & {NUM_Q{ctrl_i.commit}};
  assign push_m   = q_mask(plan.push_q) & {NUM_Q{ctrl_i.commit}};
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    popped = '0;
    for (int i = 0; i < NUM_Q; i++) begin
      if (pop_sel[i]) popped = rd_q[i];
    end
  end

  always_comb begin
    case (plan.push_src)
      SRC_PID: push_data = pid_q;
      SRC_RUN: push_data = run_id_q;
      SRC_POP: push_data = popped;
      default: push_data = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_Q; i++) begin
      empty_v[i] = (cnt_q[i] == '0);
      full_v[i]  = (cnt_q[i] == CNT_W'(MAX_PROCS));
      head_d[i]  = pop_m[i]  ? ptr_next(head_q[i]) : head_q[i];
      tail_d[i]  = push_m[i] ? ptr_next(tail_q[i]) : tail_q[i];
      case ({push_m[i], pop_m[i]})
        2'b10:   cnt_d[i] = cnt_q[i] + CNT_W'(1);
        2'b01:   cnt_d[i] = cnt_q[i] - CNT_W'(1);
        default: cnt_d[i] = cnt_q[i];
      endcase
    end
  end

  always_comb begin
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    if (ctrl_i.commit) begin
      case (plan.run_op)
        RUN_SET: begin
          run_valid_d = 1'b1;
          run_id_d    = popped;
        end
        RUN_CLEAR: begin
          run_valid_d = 1'b0;
          run_id_d    = '0;
        end
        default: begin
          run_valid_d = run_valid_q;
        end
      endcase
    end
  end

  // queue memories: registered head read, commit writes the tail
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_Q; i++) begin
      if (ctrl_i.rd_en) rd_q[i] <= mem_q[i][head_q[i]];
      if (push_m[i]) mem_q[i][tail_q[i]] <= push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) pid_q <= pid_i;
    run_id_q <= run_id_d;
    if (ctrl_i.commit) begin
      out_status_q <= plan.status;
      out_run_v_q  <= run_valid_d;
      out_run_id_q <= run_valid_d ? run_id_d : '0;
      out_rel_v_q  <= plan.rel;
      out_rel_id_q <= plan.rel ? run_id_q : '0;
      for (int i = 0; i < NUM_Q; i++) begin
        out_cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_Q; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      run_valid_q <= run_valid_d;
      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      for (int i = 0; i < NUM_Q; i++) begin
        head_q[i] <= head_d[i];
        tail_q[i] <= tail_d[i];
        cnt_q[i]  <= cnt_d[i];
      end
    end
  end

  assign stat_o.run_valid = run_valid_q;
  assign stat_o.empty     = empty_v;
  assign stat_o.full      = full_v;
  assign stat_o.out_free  = out_free;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.running_valid  = out_run_v_q;
  assign rsp_o.running_id     = out_run_id_q;
  assign rsp_o.released_valid = out_rel_v_q;
  assign rsp_o.released_id    = out_rel_id_q;
  assign rsp_o.new_count      = out_cnt_q[IDX_NEW];
  assign rsp_o.ready_count    = out_cnt_q[IDX_READY];
  assign rsp_o.blocked_count  = out_cnt_q[IDX_BLOCKED];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[IDX_NEW] <= CNT_W'(MAX_PROCS)) && (cnt_q[IDX_READY] <= CNT_W'(MAX_PROCS))
      && (cnt_q[IDX_BLOCKED] <= CNT_W'(MAX_PROCS)))
    else $error("queue count above capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> ((pop_m & empty_v) == '0))
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> ((push_m & full_v & ~pop_m) == '0))
    else $error("push into full queue");

endmodule
`default_nettype wire

### rtl/process_state_queue_manager_top.sv
// Top level: process state queue manager, controller plus queue datapath.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    command, process_id
//   rsp_o    out  valid/ready    status, running_valid/id, released_valid/id, 3 counts
//
// Each request runs through accept, registered head read of the queue memories,
// then commit of pointers, counts, running slot and the result register.
// Reset (async, active low) empties all queues and the running slot; queue memory
// contents are not cleared, only written entries are read.
// A result waiting on rsp_o does not block the next accept; the commit cycle waits
// until the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module process_state_queue_manager_top import psqm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psqm_req_if.sink   req_i,
  psqm_rsp_if.source rsp_o
);

  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;

  psqm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .stat_i (dp_stat),
    .ctrl_o (dp_ctrl)
  );

  psqm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pid_i  (req_i.process_id),
    .ctrl_i (dp_ctrl),
    .stat_o (dp_stat),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire
